// ===== rtl/ega_pkg.sv =====
// shared types and codes for the embedding gradient accumulator
`timescale 1ns / 1ps
package ega_pkg;

	// result status codes
	typedef enum logic [1:0] {
		STATUS_DONE    = 2'd0,
		STATUS_IGNORED = 2'd1,
		STATUS_RANGE   = 2'd2
	} status_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPDATE
	} state_t;

	localparam int LABEL_W = 11;
	localparam int COL_W   = 6;
	localparam int DATA_W  = 32;

endpackage

// ===== rtl/embedding_gradient_accumulate.sv =====
// top level: gradient table with saturating read-modify-write sequencer
`timescale 1ns / 1ps
//
// Embedding gradient accumulator. Holds a table of ROWS x COLS signed Q16.16
// accumulators in one single-port memory, addressed at label * COLS + col.
// Input channel: a beat is taken at a rising edge with start high and busy
// low. req_type 0 adds grad_value, saturating, into the addressed entry and
// returns the new sum; req_type 1 returns the stored entry unchanged.
// An accumulate beat whose label equals the skip label is skipped (status 1);
// a label or column outside the table is skipped (status 2). Skipped beats
// return sum_value 0. end_of_batch is echoed on batch_done.
// Result channel: every input beat gives exactly one result beat, shown for
// one cycle with done high; the receiver takes it as it comes.
// Timing: the entry is read in the accept cycle and written in the following
// update cycle, with busy high, so no new beat is taken until that cycle is
// over. The result beat is registered at the end of the update cycle.
// Reset: the skip label returns to -1 and the sequencer sweeps the memory to
// zero, one entry a cycle over all ROWS * COLS entries, with busy high.
// cfg_we / cfg_wdata write the skip label at any edge.
//
module embedding_gradient_accumulate
	import ega_pkg::*;
#(
	parameter int ROWS = 1024,
	parameter int COLS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic signed [LABEL_W-1:0] cfg_wdata,
	input  logic                      start,
	output logic                      busy,
	input  logic                      req_type,
	input  logic signed [LABEL_W-1:0] label,
	input  logic        [COL_W-1:0]   col,
	input  logic signed [DATA_W-1:0]  grad_value,
	input  logic                      end_of_batch,
	output logic                      done,
	output logic signed [DATA_W-1:0]  sum_value,
	output logic        [1:0]         status,
	output logic                      batch_done
);

	localparam int DEPTH = ROWS * COLS;
	localparam int AW    = $clog2(DEPTH);

	state_t state_q, state_nx;

	logic signed [LABEL_W-1:0] ignore_q;
	logic [AW-1:0]             clr_cnt_q;
	logic [AW-1:0]             addr_q;
	logic [DATA_W-1:0]         grad_q;
	status_t                   stat_q;
	logic                      wr_q;
	logic                      eob_q;
	logic [DATA_W-1:0]         rdata_q;

	logic                      accept;
	logic                      label_ok;
	logic                      col_ok;
	logic                      in_ignored;
	status_t                   in_stat;
	logic [AW-1:0]             in_addr;
	logic [DATA_W:0]           sum_wide;
	logic [DATA_W-1:0]         sum_sat;
	logic [DATA_W-1:0]         result;

	logic                      mem_we;
	logic [AW-1:0]             mem_addr;
	logic [DATA_W-1:0]         mem_wdata;
	logic                      clr_last;

	logic [DATA_W-1:0]         mem [DEPTH];

	// ignore label register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ignore_q <= '1;
		end else if (cfg_we) begin
			ignore_q <= cfg_wdata;
		end
	end

	// classify the incoming beat and form its table address
	assign accept     = start && !busy;
	assign label_ok   = !label[LABEL_W-1] && (32'(label[LABEL_W-2:0]) < ROWS);
	assign col_ok     = 32'(col) < COLS;
	assign in_ignored = !req_type && (label == ignore_q);
	assign in_addr    = AW'(label[LABEL_W-2:0]) * AW'(COLS) + AW'(col);

	always_comb begin
		priority if (in_ignored) begin
			in_stat = STATUS_IGNORED;
		end else if (!label_ok || !col_ok) begin
			in_stat = STATUS_RANGE;
		end else begin
			in_stat = STATUS_DONE;
		end
	end

	// item registers, loaded on accept
	always_ff @(posedge clk) begin
		if (accept) begin
			addr_q <= in_addr;
			grad_q <= grad_value;
			stat_q <= in_stat;
			wr_q   <= !req_type && (in_stat == STATUS_DONE);
			eob_q  <= end_of_batch;
		end
	end

	// saturating add of stored entry and gradient
	assign sum_wide = {rdata_q[DATA_W-1], rdata_q} + {grad_q[DATA_W-1], grad_q};
	always_comb begin
		if (sum_wide[DATA_W] != sum_wide[DATA_W-1]) begin
			sum_sat = sum_wide[DATA_W] ? {1'b1, {(DATA_W-1){1'b0}}}
			                           : {1'b0, {(DATA_W-1){1'b1}}};
		end else begin
			sum_sat = sum_wide[DATA_W-1:0];
		end
	end

	always_comb begin
		if (stat_q != STATUS_DONE) begin
			result = '0;
		end else if (wr_q) begin
			result = sum_sat;
		end else begin
			result = rdata_q;
		end
	end

	assign clr_last = clr_cnt_q == AW'(DEPTH - 1);

	// sequencer: next state and memory port control
	always_comb begin
		state_nx  = state_q;
		busy      = 1'b1;
		mem_we    = 1'b0;
		mem_addr  = in_addr;
		mem_wdata = sum_sat;
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_addr  = clr_cnt_q;
				mem_wdata = '0;
				if (clr_last) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_nx = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				mem_we   = wr_q;
				mem_addr = addr_q;
				state_nx = ST_IDLE;
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// state register and clear counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
		end
	end

	// single-port gradient table
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end else begin
			rdata_q <= mem[mem_addr];
		end
	end

	// result beat registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= state_q == ST_UPDATE;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_UPDATE) begin
			sum_value  <= result;
			status     <= stat_q;
			batch_done <= eob_q;
		end
	end

endmodule

// ===== rtl/ega_checker.sv =====
// port-level checks for the embedding gradient accumulator, bound to the top
`timescale 1ns / 1ps
module ega_checker
	import ega_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input logic [DATA_W-1:0] sum_value,
	input logic [1:0]        status
);

	// every accepted beat yields a result beat after its update cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##2 done)
		else $error("no result beat after accepted input beat");

	// no result beat without an accepted input beat
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result beat without accepted input beat");

	// the block is busy in the cycle after an accept
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("input beat taken in update cycle");

	// skipped beats return zero
	a_skip_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == STATUS_IGNORED || status == STATUS_RANGE)
		|-> sum_value == '0)
		else $error("skipped beat returned nonzero sum");

endmodule

bind embedding_gradient_accumulate ega_checker u_ega_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.sum_value (sum_value),
	.status    (status)
);
